### sv/csa_pkg.sv
// Shared types and constants for the chunked slot allocator.
// No dependencies; the files that use it refer to it by scoped names.
package csa_pkg;

  // Fixed field widths on the stream ports
  localparam int CHUNK_W    = 4;
  localparam int SLOT_W     = 6;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  // Request kind (in_tuser)
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status (out_tuser)
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_INACTIVE = 2'd2
  } csa_status_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOK   = 4'b0010,
    ST_META   = 4'b0100,
    ST_COMMIT = 4'b1000
  } csa_state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch request word
    logic look;     // pick chunk, issue meta/active reads
    logic meta;     // decide slot, issue stack read
    logic commit;   // write state, load result register
  } csa_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic out_room; // result register can take a new word this cycle
  } csa_stat_t;

endpackage

### sv/csa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/csa_ctrl.sv
// Sequencing state machine for the chunked slot allocator.
// Depends on csa_pkg (state, command and status types).
module csa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  csa_pkg::csa_stat_t   stat,
  output csa_pkg::csa_cmd_t    cmd
);

  csa_pkg::csa_state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    case (state_r)
      csa_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = csa_pkg::ST_LOOK;
        end
      end
      csa_pkg::ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = csa_pkg::ST_META;
      end
      csa_pkg::ST_META: begin
        cmd.meta  = 1'b1;
        state_nxt = csa_pkg::ST_COMMIT;
      end
      csa_pkg::ST_COMMIT: begin
        // hold until the result register frees up
        if (stat.out_room) begin
          cmd.commit = 1'b1;
          state_nxt  = csa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/csa_datapath.sv
// Datapath: request register, per-chunk room flags, chunk metadata,
// free-slot stacks, active flags and the result register.
// Depends on csa_pkg and csa_ram.
module csa_datapath #(
  parameter int SLOTS  = 64,
  parameter int CHUNKS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csa_pkg::csa_cmd_t                 cmd,
  output csa_pkg::csa_stat_t                stat,
  input  logic [csa_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [csa_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [csa_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [csa_pkg::OUT_USER_W-1:0]    out_tuser
);

  localparam int SW   = $clog2(SLOTS);
  localparam int HW   = $clog2(SLOTS + 1);
  localparam int CW   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int NC   = 1 << CW;
  localparam int OW   = $clog2(CHUNKS + 1);
  localparam int CE_W = ((CW > csa_pkg::CHUNK_W) ? CW : csa_pkg::CHUNK_W) + 1;
  localparam int SE_W = ((SW > csa_pkg::SLOT_W) ? SW : csa_pkg::SLOT_W) + 1;
  localparam int AW   = CW + SW;
  localparam int PAD_W = csa_pkg::OUT_DATA_W - csa_pkg::CHUNK_W - csa_pkg::SLOT_W - 1;

  // ---------------- request register ----------------
  logic                        kind_r;
  logic [csa_pkg::CHUNK_W-1:0] csel_r;
  logic [csa_pkg::SLOT_W-1:0]  ssel_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_tuser[0];
      csel_r <= in_tdata[csa_pkg::CHUNK_W-1:0];
      ssel_r <= in_tdata[csa_pkg::CHUNK_W +: csa_pkg::SLOT_W];
    end
  end

  logic [CE_W-1:0] csel_ext;
  logic [SE_W-1:0] ssel_ext;
  logic [CW-1:0]   csel_idx;
  logic [SW-1:0]   ssel_idx;

  assign csel_ext = CE_W'(csel_r);
  assign ssel_ext = SE_W'(ssel_r);
  assign csel_idx = csel_ext[CW-1:0];
  assign ssel_idx = ssel_ext[SW-1:0];

  // ---------------- control state ----------------
  logic [NC-1:0] room_r;         // chunk open and not full
  logic [OW-1:0] chunks_open_r;

  // ---------------- look stage ----------------
  logic [CW-1:0] first_idx;
  logic          any_room;

  always_comb begin
    first_idx = '0;
    any_room  = 1'b0;
    for (int i = NC - 1; i >= 0; i--) begin
      if (room_r[i]) begin
        first_idx = CW'(i);
        any_room  = 1'b1;
      end
    end
  end

  logic          all_open;
  logic [CW-1:0] look_chunk;
  logic          look_in_range;
  logic          look_opened;

  assign all_open      = (chunks_open_r == OW'(CHUNKS));
  assign look_in_range = (csel_ext < CE_W'(CHUNKS)) && (ssel_ext < SE_W'(SLOTS));
  assign look_opened   = (csel_ext < CE_W'(chunks_open_r));

  always_comb begin
    if (kind_r == csa_pkg::KIND_FREE) begin
      look_chunk = csel_idx;
    end else if (any_room) begin
      look_chunk = first_idx;
    end else begin
      look_chunk = chunks_open_r[CW-1:0];
    end
  end

  logic [CW-1:0] chunk_r;
  logic          new_r;
  logic          nospace_r;
  logic          in_range_r;
  logic          opened_r;

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      chunk_r    <= look_chunk;
      // only an allocate opens a chunk; a free always uses stored metadata
      new_r      <= (kind_r == csa_pkg::KIND_ALLOC) && !any_room;
      nospace_r  <= !any_room && all_open;
      in_range_r <= look_in_range;
      opened_r   <= look_opened;
    end
  end

  // ---------------- memories ----------------
  logic          meta_we;
  logic [2*HW-1:0] meta_wdata, meta_rdata;
  logic          act_we, act_wdata, act_rdata;
  logic [AW-1:0] act_waddr;
  logic          stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_rdata;

  // {high_water, free_depth} per chunk
  csa_ram #(.WIDTH(2 * HW), .DEPTH(NC)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (chunk_r),
    .wdata (meta_wdata),
    .re    (cmd.look),
    .raddr (look_chunk),
    .rdata (meta_rdata)
  );

  // active flag per slot; only slots below high water are trusted
  csa_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_active (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .re    (cmd.look),
    .raddr ({csel_idx, ssel_idx}),
    .rdata (act_rdata)
  );

  // freed slot numbers, one LIFO region per chunk
  csa_ram #(.WIDTH(SW), .DEPTH(1 << AW)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (ssel_idx),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // ---------------- meta stage ----------------
  logic [HW-1:0] cur_hw, cur_depth, depth_dec;
  logic          pop;
  logic          free_ok;

  assign cur_hw    = new_r ? '0 : meta_rdata[2*HW-1:HW];
  assign cur_depth = new_r ? '0 : meta_rdata[HW-1:0];
  assign depth_dec = cur_depth - 1'b1;
  assign pop       = (cur_depth != '0);
  assign free_ok   = in_range_r && opened_r && (HW'(ssel_idx) < cur_hw) && act_rdata;

  assign stk_re    = cmd.meta && (kind_r == csa_pkg::KIND_ALLOC) && pop;
  assign stk_raddr = {chunk_r, depth_dec[SW-1:0]};

  logic [HW-1:0] nxt_hw_r, nxt_depth_r;
  logic [SW-1:0] pick_r;     // fresh slot on allocate, push index on free
  logic          pop_r;
  logic          free_ok_r;

  always_ff @(posedge clk) begin
    if (cmd.meta) begin
      free_ok_r <= free_ok;
      if (kind_r == csa_pkg::KIND_ALLOC) begin
        pop_r       <= pop;
        pick_r      <= cur_hw[SW-1:0];
        nxt_hw_r    <= pop ? cur_hw : cur_hw + 1'b1;
        nxt_depth_r <= pop ? depth_dec : cur_depth;
      end else begin
        pop_r       <= 1'b0;
        pick_r      <= cur_depth[SW-1:0];
        nxt_hw_r    <= cur_hw;
        nxt_depth_r <= cur_depth + 1'b1;
      end
    end
  end

  // ---------------- commit stage ----------------
  logic [SW-1:0] alloc_slot;
  logic          full_after;
  logic          do_alloc, do_free;

  assign alloc_slot = pop_r ? stk_rdata : pick_r;
  assign full_after = (nxt_depth_r == '0) && (nxt_hw_r == HW'(SLOTS));
  assign do_alloc   = cmd.commit && (kind_r == csa_pkg::KIND_ALLOC) && !nospace_r;
  assign do_free    = cmd.commit && (kind_r == csa_pkg::KIND_FREE) && free_ok_r;

  assign meta_we    = do_alloc || do_free;
  assign meta_wdata = {nxt_hw_r, nxt_depth_r};
  assign act_we     = do_alloc || do_free;
  assign act_waddr  = do_alloc ? {chunk_r, alloc_slot} : {chunk_r, ssel_idx};
  assign act_wdata  = do_alloc;
  assign stk_we     = do_free;
  assign stk_waddr  = {chunk_r, pick_r};

  logic [NC-1:0] room_nxt;
  logic [OW-1:0] chunks_open_nxt;

  always_comb begin
    room_nxt        = room_r;
    chunks_open_nxt = chunks_open_r;
    if (do_alloc) begin
      room_nxt[chunk_r] = !full_after;
      if (new_r) begin
        chunks_open_nxt = chunks_open_r + 1'b1;
      end
    end else if (do_free) begin
      room_nxt[chunk_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_r        <= '0;
      chunks_open_r <= '0;
    end else begin
      room_r        <= room_nxt;
      chunks_open_r <= chunks_open_nxt;
    end
  end

  // ---------------- result register ----------------
  logic [CE_W-1:0]             chunk_ext;
  logic [SE_W-1:0]             slot_ext;
  csa_pkg::csa_status_t        res_status;
  logic [csa_pkg::CHUNK_W-1:0] res_chunk;
  logic [csa_pkg::SLOT_W-1:0]  res_slot;
  logic                        res_full;

  assign chunk_ext = CE_W'(chunk_r);
  assign slot_ext  = SE_W'(alloc_slot);

  always_comb begin
    if (kind_r == csa_pkg::KIND_ALLOC) begin
      if (nospace_r) begin
        res_status = csa_pkg::STAT_NO_SPACE;
        res_chunk  = '0;
        res_slot   = '0;
        res_full   = 1'b1;
      end else begin
        res_status = csa_pkg::STAT_OK;
        res_chunk  = chunk_ext[csa_pkg::CHUNK_W-1:0];
        res_slot   = slot_ext[csa_pkg::SLOT_W-1:0];
        res_full   = full_after;
      end
    end else if (free_ok_r) begin
      res_status = csa_pkg::STAT_OK;
      res_chunk  = csel_r;
      res_slot   = ssel_r;
      res_full   = 1'b0;
    end else begin
      res_status = csa_pkg::STAT_INACTIVE;
      res_chunk  = csel_r;
      res_slot   = ssel_r;
      res_full   = in_range_r && opened_r && !room_r[chunk_r];
    end
  end

  logic                        out_valid_r;
  csa_pkg::csa_status_t        out_status_r;
  logic [csa_pkg::CHUNK_W-1:0] out_chunk_r;
  logic [csa_pkg::SLOT_W-1:0]  out_slot_r;
  logic                        out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_chunk_r  <= res_chunk;
      out_slot_r   <= res_slot;
      out_full_r   <= res_full;
    end
  end

  assign stat.out_room = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {{PAD_W{1'b0}}, out_full_r, out_slot_r, out_chunk_r};
  assign out_tuser     = out_status_r;

endmodule

### sv/chunked_slot_allocator_top.sv
// Chunked slot allocator, top level. Depends on csa_pkg, csa_ctrl, csa_datapath.
// A request word is accepted, then passes look with metadata read, stack read and commit;
//   the result word is registered at commit. A new request is accepted only after commit,
//   and commit waits while out_tready holds back a waiting result.
// Reset (rst_n low, synchronous): no chunks open, no result pending; the slot
//   RAMs need no clearing since only slots below a chunk's high water are read.
module chunked_slot_allocator_top #(
  parameter int SLOTS  = 64,   // slots per chunk, 2..64
  parameter int CHUNKS = 16    // number of chunks, 1..16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [csa_pkg::IN_DATA_W-1:0]     in_tdata,   // [3:0] chunk_sel, [9:4] slot_sel
  input  logic [csa_pkg::IN_USER_W-1:0]     in_tuser,   // [0] kind: 0 allocate, 1 free
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [csa_pkg::OUT_DATA_W-1:0]    out_tdata,  // [3:0] chunk_out, [9:4] slot_out,
                                                        // [10] chunk_now_full
  output logic [csa_pkg::OUT_USER_W-1:0]    out_tuser   // [1:0] status
);

  // The controller walks each word through four steps; the datapath owns all
  // storage. Allocation picks the lowest chunk with its room flag set, or opens
  // the next chunk; a free checks the slot's active flag before pushing it.
  csa_pkg::csa_cmd_t  cmd;
  csa_pkg::csa_stat_t stat;

  csa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csa_datapath #(
    .SLOTS  (SLOTS),
    .CHUNKS (CHUNKS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### sv/csa_checker.sv
// Port-level checks for the chunked slot allocator, bound to the top level.
// Depends on csa_pkg and chunked_slot_allocator_top.
module csa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [csa_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [csa_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [csa_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [csa_pkg::OUT_USER_W-1:0] out_tuser
);

  // stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("request word changed while stalled");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // one request in flight: no accept on the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one in progress");

  // no-space result carries zero chunk/slot and the full flag
  a_no_space_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == csa_pkg::STAT_NO_SPACE) |->
      out_tdata[csa_pkg::CHUNK_W + csa_pkg::SLOT_W - 1:0] == '0 &&
      out_tdata[csa_pkg::CHUNK_W + csa_pkg::SLOT_W])
    else $error("malformed no-space result");

  // status stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == csa_pkg::STAT_OK) || (out_tuser == csa_pkg::STAT_NO_SPACE) ||
                   (out_tuser == csa_pkg::STAT_INACTIVE))
    else $error("undefined status code");

endmodule

bind chunked_slot_allocator_top csa_checker u_csa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
